[rtl/tbp_pkg.sv]
// Shared types, constants and helper functions for the tournament branch predictor.
package tbp_pkg;

    localparam int INDEX_BITS  = 10;
    localparam int HIST_BITS   = 10;
    localparam int TBL_DEPTH   = 1 << INDEX_BITS;
    localparam int CTR_BITS    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic [INDEX_BITS-1:0] idx_t;
    typedef logic [HIST_BITS-1:0]  hist_t;
    typedef logic [CTR_BITS-1:0]   ctr_t;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam ctr_t CTR_MAX   = '1;
    localparam ctr_t CTR_MIN   = '0;
    localparam ctr_t CTR_TAKEN = ctr_t'(2);

    typedef struct packed {
        logic        kind;
        logic [31:0] branch_address;
        logic        outcome_taken;
    } req_t;

    typedef struct packed {
        logic predict_taken;
        logic chose_global;
        logic local_guess;
        logic global_guess;
    } rsp_t;

    typedef struct packed {
        logic is_update;
        logic taken;
        idx_t index;
    } work_t;

    function automatic idx_t fold_index(logic [31:0] addr);
        logic [29:0] a;
        begin
            a = addr[31:2];
            return idx_t'(a) ^ idx_t'(a >> INDEX_BITS) ^ idx_t'(a >> (2 * INDEX_BITS));
        end
    endfunction

    function automatic idx_t hist_to_idx(hist_t h);
        return idx_t'(h);
    endfunction

    function automatic ctr_t ctr_train(ctr_t c, logic up);
        ctr_t r;
        begin
            r = c;
            if (up)
            begin
                if (c != CTR_MAX)
                    r = c + ctr_t'(1);
            end
            else
            begin
                if (c != CTR_MIN)
                    r = c - ctr_t'(1);
            end
            return r;
        end
    endfunction

    function automatic logic ctr_high(ctr_t c);
        return c >= CTR_TAKEN;
    endfunction

endpackage

[rtl/tbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tbp_front.sv]
// Front end: accepts requests, folds the address into a table index and queues the work.
module tbp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  tbp_pkg::req_t req,
    input  logic          clearing,
    output logic          item_valid,
    output tbp_pkg::work_t item,
    input  logic          item_take
);
    import tbp_pkg::*;

    work_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 accept;
    logic                 take;
    work_t                new_item;

    assign full       = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH)) || clearing;
    assign accept     = push && !full;
    assign item_valid = (count_reg != '0);
    assign take       = item_valid && item_take;
    assign item       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.is_update = (req.kind == KIND_UPDATE);
        new_item.taken     = req.outcome_taken;
        new_item.index     = fold_index(req.branch_address);
    end

    always_comb
    begin
        wr_ptr_next = accept ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (accept && !take)
            count_next = count_reg + (QPTR_BITS+1)'(1);
        else if (take && !accept)
            count_next = count_reg - (QPTR_BITS+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            entry_reg[wr_ptr_reg] <= new_item;
    end

endmodule

[rtl/tbp_back.sv]
// Back end: table lookups, training, the reset clearing pass and the result register.
module tbp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  tbp_pkg::work_t item,
    output logic           item_take,
    output logic           clearing,
    output logic           empty,
    input  logic           pop,
    output tbp_pkg::rsp_t  rsp
);
    import tbp_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_EVAL  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    idx_t   clr_cnt_reg, clr_cnt_next;
    logic   out_valid_reg, out_valid_next;
    hist_t  ghist_reg, ghist_next;
    work_t  cur_reg;
    idx_t   gi_reg;
    idx_t   li_reg;
    rsp_t   rsp_reg;

    ctr_t   cho_rdata, loc_rdata, gsh_rdata;
    hist_t  lh_rdata;
    logic   rd_first, rd_second;
    idx_t   gi_new, li_new;
    logic   fire, do_write;
    logic   local_guess, global_guess, chose_global;
    logic   lok, gok;
    ctr_t   cho_new;
    rsp_t   rsp_new;

    logic   we;
    idx_t   cho_waddr, lh_waddr, loc_waddr, gsh_waddr;
    ctr_t   cho_wdata, loc_wdata, gsh_wdata;
    hist_t  lh_wdata;

    assign clearing  = (state_reg == ST_CLEAR);
    assign item_take = (state_reg == ST_IDLE);
    assign rd_first  = (state_reg == ST_IDLE) && item_valid;
    assign rd_second = (state_reg == ST_READ);
    assign gi_new    = item.index ^ hist_to_idx(ghist_reg);
    assign li_new    = cur_reg.index ^ hist_to_idx(lh_rdata);
    assign fire      = (state_reg == ST_EVAL) && (!out_valid_reg || pop);
    assign do_write  = fire && cur_reg.is_update;

    always_comb
    begin
        local_guess  = ctr_high(loc_rdata);
        global_guess = ctr_high(gsh_rdata);
        chose_global = ctr_high(cho_rdata);
        lok          = (local_guess == cur_reg.taken);
        gok          = (global_guess == cur_reg.taken);
        cho_new      = cho_rdata;
        if (gok && !lok)
            cho_new = ctr_train(cho_rdata, 1'b1);
        else if (lok && !gok)
            cho_new = ctr_train(cho_rdata, 1'b0);
        rsp_new.predict_taken = chose_global ? global_guess : local_guess;
        rsp_new.chose_global  = chose_global;
        rsp_new.local_guess   = local_guess;
        rsp_new.global_guess  = global_guess;
    end

    always_comb
    begin
        we        = clearing || do_write;
        cho_waddr = clearing ? clr_cnt_reg : cur_reg.index;
        lh_waddr  = clearing ? clr_cnt_reg : cur_reg.index;
        loc_waddr = clearing ? clr_cnt_reg : li_reg;
        gsh_waddr = clearing ? clr_cnt_reg : gi_reg;
        cho_wdata = clearing ? CTR_MIN : cho_new;
        loc_wdata = clearing ? CTR_MIN : ctr_train(loc_rdata, cur_reg.taken);
        gsh_wdata = clearing ? CTR_MIN : ctr_train(gsh_rdata, cur_reg.taken);
        lh_wdata  = clearing ? '0 : {lh_rdata[HIST_BITS-2:0], cur_reg.taken};
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        ghist_next     = ghist_reg;
        if (pop && out_valid_reg)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + idx_t'(1);
                if (clr_cnt_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (cur_reg.is_update)
                        ghist_next = {ghist_reg[HIST_BITS-2:0], cur_reg.taken};
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            ghist_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            ghist_reg     <= ghist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_first)
        begin
            cur_reg <= item;
            gi_reg  <= gi_new;
        end
        if (rd_second)
            li_reg <= li_new;
        if (fire)
            rsp_reg <= rsp_new;
    end

    assign empty = !out_valid_reg;
    assign rsp   = rsp_reg;

    tbp_ram #(.WIDTH(CTR_BITS), .DEPTH(TBL_DEPTH)) u_chooser (
        .clk   (clk),
        .we    (we),
        .waddr (cho_waddr),
        .wdata (cho_wdata),
        .re    (rd_first),
        .raddr (item.index),
        .rdata (cho_rdata)
    );

    tbp_ram #(.WIDTH(HIST_BITS), .DEPTH(TBL_DEPTH)) u_local_hist (
        .clk   (clk),
        .we    (we),
        .waddr (lh_waddr),
        .wdata (lh_wdata),
        .re    (rd_first),
        .raddr (item.index),
        .rdata (lh_rdata)
    );

    tbp_ram #(.WIDTH(CTR_BITS), .DEPTH(TBL_DEPTH)) u_gshare_ctr (
        .clk   (clk),
        .we    (we),
        .waddr (gsh_waddr),
        .wdata (gsh_wdata),
        .re    (rd_first),
        .raddr (gi_new),
        .rdata (gsh_rdata)
    );

    tbp_ram #(.WIDTH(CTR_BITS), .DEPTH(TBL_DEPTH)) u_local_ctr (
        .clk   (clk),
        .we    (we),
        .waddr (loc_waddr),
        .wdata (loc_wdata),
        .re    (rd_second),
        .raddr (li_new),
        .rdata (loc_rdata)
    );

endmodule

[rtl/tournament_branch_predictor.sv]
// Top level of the tournament branch predictor: front end, work queue and back end.
//
//   Channel   Handshake     Payload  Meaning
//   request   push / full   req      lookup or update for one branch address
//   result    empty / pop   rsp      predictions as they stood before the request
//
// In the back end each request passes the chooser, local history and gshare reads, then
// the local counter read that depends on the local history, then evaluation and
// write-back. The front end queues two requests so it keeps accepting meanwhile.
// After reset a clearing pass zeroes all 2^INDEX_BITS entries of every table; full stays high.
// A result waiting in the output register stalls only the evaluation step.
module tournament_branch_predictor (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  tbp_pkg::req_t req,
    output logic          empty,
    input  logic          pop,
    output tbp_pkg::rsp_t rsp
);
    import tbp_pkg::*;

    logic  item_valid;
    logic  item_take;
    logic  clearing;
    work_t item;

    tbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req        (req),
        .clearing   (clearing),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    tbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .clearing   (clearing),
        .empty      (empty),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

[tb/tournament_branch_predictor_tb.sv]
// Testbench for the tournament branch predictor with a scoreboard that models its tables.
`timescale 1ns / 1ps

module tournament_branch_predictor_tb;
    import tbp_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int IDLE_PERCENT   = 8;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 20;
    localparam int POOL_SIZE      = 8;
    localparam int MAX_PRINTED    = 40;

    class branch_scoreboard;
        ctr_t  chooser_ctr[TBL_DEPTH];
        hist_t local_hist[TBL_DEPTH];
        ctr_t  local_ctr[TBL_DEPTH];
        ctr_t  gshare_ctr[TBL_DEPTH];
        hist_t global_hist;
        rsp_t  prediction_q[$];
        int    mismatches;

        function new();
            for (int i = 0; i < TBL_DEPTH; i++)
            begin
                chooser_ctr[i] = '0;
                local_hist[i]  = '0;
                local_ctr[i]   = '0;
                gshare_ctr[i]  = '0;
            end
            global_hist = '0;
            mismatches  = 0;
        endfunction

        function idx_t branch_index(logic [31:0] pc);
            return pc[2 +: INDEX_BITS] ^ pc[2 + INDEX_BITS +: INDEX_BITS]
                 ^ pc[2 + 2 * INDEX_BITS +: INDEX_BITS];
        endfunction

        function ctr_t bump(ctr_t c, logic up);
            if (up)
                return (c == '1) ? c : c + 1'b1;
            return (c == '0) ? c : c - 1'b1;
        endfunction

        function int pending();
            return prediction_q.size();
        endfunction

        function void note_request(req_t r);
            idx_t h;
            idx_t li;
            idx_t gi;
            hist_t lh;
            rsp_t p;
            h  = branch_index(r.branch_address);
            lh = local_hist[h];
            li = h ^ idx_t'(lh);
            gi = h ^ idx_t'(global_hist);
            p.local_guess   = local_ctr[li][1];
            p.global_guess  = gshare_ctr[gi][1];
            p.chose_global  = chooser_ctr[h][1];
            p.predict_taken = p.chose_global ? p.global_guess : p.local_guess;
            prediction_q.push_back(p);
            if (r.kind == KIND_UPDATE)
            begin
                if (p.global_guess == r.outcome_taken && p.local_guess != r.outcome_taken)
                    chooser_ctr[h] = bump(chooser_ctr[h], 1'b1);
                else if (p.local_guess == r.outcome_taken && p.global_guess != r.outcome_taken)
                    chooser_ctr[h] = bump(chooser_ctr[h], 1'b0);
                local_ctr[li]  = bump(local_ctr[li], r.outcome_taken);
                local_hist[h]  = {lh[HIST_BITS-2:0], r.outcome_taken};
                gshare_ctr[gi] = bump(gshare_ctr[gi], r.outcome_taken);
                global_hist    = {global_hist[HIST_BITS-2:0], r.outcome_taken};
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTED)
                $display("%0t: mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (prediction_q.size() == 0)
            begin
                report_mismatch($sformatf("result %b with no request outstanding", got));
                return;
            end
            want = prediction_q.pop_front();
            if (got.predict_taken !== want.predict_taken)
                report_mismatch($sformatf("predict_taken got %b want %b",
                                          got.predict_taken, want.predict_taken));
            if (got.chose_global !== want.chose_global)
                report_mismatch($sformatf("chose_global got %b want %b",
                                          got.chose_global, want.chose_global));
            if (got.local_guess !== want.local_guess)
                report_mismatch($sformatf("local_guess got %b want %b",
                                          got.local_guess, want.local_guess));
            if (got.global_guess !== want.global_guess)
                report_mismatch($sformatf("global_guess got %b want %b",
                                          got.global_guess, want.global_guess));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    req_t req;
    logic empty;
    logic pop;
    rsp_t rsp;

    branch_scoreboard sb;
    int          cycles = 0;
    logic        no_gaps;
    int          hold_requests = 0;
    int          holds_done = 0;
    logic [31:0] pool_pc[POOL_SIZE];
    int          pool_visits[POOL_SIZE];

    tournament_branch_predictor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .empty (empty),
        .pop   (pop),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_request(req);
            if (pop && !empty)
                sb.check_result(rsp);
        end
    end

    function automatic req_t make_request(logic kind, logic [31:0] pc, logic taken);
        req_t r;
        r.kind           = kind;
        r.branch_address = pc;
        r.outcome_taken  = taken;
        return r;
    endfunction

    function automatic req_t random_request();
        int   slot;
        int   n;
        logic taken;
        logic kind;
        kind = ($urandom_range(0, 99) < 65) ? KIND_UPDATE : KIND_LOOKUP;
        if ($urandom_range(0, 99) < 30)
            return make_request(kind, $urandom(), 1'($urandom_range(0, 1)));
        slot = $urandom_range(0, POOL_SIZE - 1);
        n = pool_visits[slot];
        pool_visits[slot] = n + 1;
        case (slot)
            0: taken = 1'b1;
            1: taken = 1'b0;
            2: taken = n[0];
            3: taken = (n % 4) != 3;
            4: taken = n[3];
            default: taken = ($urandom_range(0, 99) < 80);
        endcase
        return make_request(kind, pool_pc[slot], taken);
    endfunction

    task automatic send_request(req_t r);
        push <= 1'b1;
        req  <= r;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic idle_sender();
        push <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done = hold_requests;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                pop <= no_gaps || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        req = '0;
        no_gaps = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_pc[i] = $urandom();
            pool_visits[i] = 0;
        end
        // Two pool entries differ in two address bits that fold onto the same index bit,
        // so they share table slots.
        pool_pc[7] = pool_pc[6] ^ 32'h0000_1000 ^ 32'h0000_0004;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Lookups at the address extremes leave the tables alone, whatever the outcome bit.
        send_request(make_request(KIND_LOOKUP, 32'h0000_0000, 1'b1));
        send_request(make_request(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0));
        // A long taken run fills both histories with ones and saturates the local and gshare counters high.
        for (int i = 0; i < 14; i++)
            send_request(make_request(KIND_UPDATE, 32'hFFFF_FFFC, 1'b1));
        send_request(make_request(KIND_LOOKUP, 32'hFFFF_FFFC, 1'b0));
        for (int i = 0; i < 6; i++)
            send_request(make_request(KIND_UPDATE, 32'hFFFF_FFFC, 1'b0));
        send_request(make_request(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b1));
        send_request(make_request(KIND_UPDATE, 32'h0000_0000, 1'b0));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 300)
                hold_requests = hold_requests + 1;
            if (i == 700)
                wait_for_drain();
            no_gaps = (i >= 800 && i < 1100);
            if (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT)
                idle_sender();
            send_request(random_request());
        end
        no_gaps = 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[tournament_branch_predictor.f]
rtl/tbp_pkg.sv
rtl/tbp_ram.sv
rtl/tbp_front.sv
rtl/tbp_back.sv
rtl/tournament_branch_predictor.sv
tb/tournament_branch_predictor_tb.sv
